>>> rtl/midi_clock_lfo_phase_follower_unit_defines.svh
// ---------------------------------------------------------------------------
// midi clock lfo phase follower: assertion macros
// shared assertion wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef MIDI_CLOCK_LFO_PHASE_FOLLOWER_UNIT_DEFINES_SVH
`define MIDI_CLOCK_LFO_PHASE_FOLLOWER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define MCLF_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define MCLF_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCLF_ASSERT(name, clk, rstn, prop, msg)
`define MCLF_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> rtl/mclf_pkg.sv
// ---------------------------------------------------------------------------
// mclf_pkg
// beat types, item kind codes and fixed constants of the phase follower
// ---------------------------------------------------------------------------
package mclf_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_SYNC     = 3'd1;
    localparam logic [2:0] KIND_START    = 3'd2;
    localparam logic [2:0] KIND_STOP     = 3'd3;
    localparam logic [2:0] KIND_CONTINUE = 3'd4;

    localparam logic [4:0]  QUARTER_LAST  = 5'd23;
    localparam logic [16:0] SUB_PER_PULSE = 17'd5461;
    localparam logic [31:0] INTERP_STEP   = 32'd682;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] rate_select;
    } mclf_in_t;

    typedef struct packed {
        logic [12:0] phase_value;
        logic        is_running;
    } mclf_out_t;

    // commands from the top level to the gap timer
    typedef struct packed {
        logic tick;
        logic sync;
        logic stop;
    } mclf_gap_cmd_t;

endpackage

>>> rtl/midi_clock_lfo_phase_follower_unit.sv
// ---------------------------------------------------------------------------
// midi_clock_lfo_phase_follower_unit
// follows a 24 ppqn sync clock and tracks a 13-bit lfo phase
// ---------------------------------------------------------------------------
// Input beats carry an item kind (time tick, sync pulse, start, stop,
// continue) and a rate select; every accepted beat yields exactly one
// result beat with the phase shifted right by the rate select and the
// running flag, both taken after the item has been applied.
// The state registers and the result register are loaded at the edge
// that accepts the beat, so m_valid rises on the next cycle. Throughput
// is one beat per cycle while the receiver keeps taking results; the
// whole update is a single pass of short logic with the 32-bit phase
// add and the output shifter as its longest path.
// s_ready is high while the result register is empty or being taken, so a
// new beat is accepted in the same cycle a pending result leaves. When the
// receiver stalls, the result holds and s_ready drops until it is taken.
// Synchronous reset empties the result register, clears the counters and
// phase, stops the follower, leaves the gap timer armed and sets the
// interpolation reload to 100. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "midi_clock_lfo_phase_follower_unit_defines.svh"

module midi_clock_lfo_phase_follower_unit
    import mclf_pkg::*;
#(
    parameter int COARSE_RATIO = 8,
    parameter int GAP_WIDTH    = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mclf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mclf_out_t m_data
);

    localparam logic [GAP_WIDTH-1:0] GAP_FULL     = {GAP_WIDTH{1'b1}};
    localparam logic [GAP_WIDTH-1:0] RELOAD_RESET = GAP_WIDTH'(100);

    logic                 s_accept;
    mclf_gap_cmd_t        gap_cmd;
    logic [GAP_WIDTH-1:0] gap_count;
    logic                 gap_good;

    logic                 running_reg, running_next;
    logic [4:0]           quarter_reg, quarter_next;
    logic [3:0]           measure_reg, measure_next;
    logic [31:0]          phase_reg, phase_next;
    logic [GAP_WIDTH-1:0] measured_gap_reg, measured_gap_next;
    logic [GAP_WIDTH-1:0] last_gap_reg, last_gap_next;
    logic [GAP_WIDTH-1:0] interp_reload_reg, interp_reload_next;
    logic [GAP_WIDTH-1:0] interp_count_reg, interp_count_next;
    logic                 interp_on_reg, interp_on_next;

    logic [4:0]           quarter_inc;
    logic [16:0]          quarter_phase;
    logic [31:0]          phase_shifted;
    logic                 m_valid_reg;
    mclf_out_t            m_data_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign gap_cmd.tick = s_accept && (s_data.kind == KIND_TICK);
    assign gap_cmd.sync = s_accept && (s_data.kind == KIND_SYNC);
    assign gap_cmd.stop = s_accept && (s_data.kind == KIND_STOP);

    mclf_gap_timer #(
        .COARSE_RATIO (COARSE_RATIO),
        .GAP_WIDTH    (GAP_WIDTH)
    ) u_gap_timer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (gap_cmd),
        .gap_count (gap_count)
    );

    assign gap_good    = running_reg && (gap_count != '0) && (gap_count != GAP_FULL);
    assign quarter_inc = quarter_reg + 1'b1;

    always_comb begin
        running_next       = running_reg;
        quarter_next       = quarter_reg;
        measure_next       = measure_reg;
        phase_next         = phase_reg;
        measured_gap_next  = measured_gap_reg;
        last_gap_next      = last_gap_reg;
        interp_reload_next = interp_reload_reg;
        interp_count_next  = interp_count_reg;
        interp_on_next     = interp_on_reg;
        quarter_phase      = '0;
        if (s_accept) begin
            unique case (s_data.kind)
                KIND_TICK: begin
                    // interpolation steps between pulses, frozen on a zero reload
                    if (interp_on_reg && (interp_reload_reg != '0)) begin
                        if (interp_count_reg >= interp_reload_reg) begin
                            interp_count_next = '0;
                            phase_next        = phase_reg + INTERP_STEP;
                        end else begin
                            interp_count_next = interp_count_reg + 1'b1;
                        end
                    end
                end
                KIND_SYNC: begin
                    if (gap_good) begin
                        interp_reload_next = measured_gap_reg;
                        measured_gap_next  = gap_count;
                        last_gap_next      = gap_count;
                        interp_on_next     = 1'b1;
                    end
                    if (quarter_reg == QUARTER_LAST) begin
                        quarter_next = '0;
                        measure_next = measure_reg + 1'b1;
                    end else begin
                        quarter_next = quarter_inc;
                    end
                    // quarter part stays below 2^17, so the measure field just sits above it
                    quarter_phase     = 17'(17'(quarter_next) * SUB_PER_PULSE);
                    phase_next        = {11'd0, measure_next, quarter_phase};
                    interp_count_next = '0;
                end
                KIND_START: begin
                    running_next       = 1'b1;
                    quarter_next       = '0;
                    measure_next       = '0;
                    phase_next         = '0;
                    measured_gap_next  = last_gap_reg;
                    interp_reload_next = last_gap_reg;
                    interp_count_next  = '0;
                end
                KIND_STOP: begin
                    running_next   = 1'b0;
                    interp_on_next = 1'b0;
                end
                KIND_CONTINUE: begin
                    running_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign phase_shifted = phase_next >> s_data.rate_select;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg       <= 1'b0;
            quarter_reg       <= '0;
            measure_reg       <= '0;
            phase_reg         <= '0;
            measured_gap_reg  <= '0;
            last_gap_reg      <= '0;
            interp_reload_reg <= RELOAD_RESET;
            interp_count_reg  <= '0;
            interp_on_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            running_reg       <= running_next;
            quarter_reg       <= quarter_next;
            measure_reg       <= measure_next;
            phase_reg         <= phase_next;
            measured_gap_reg  <= measured_gap_next;
            last_gap_reg      <= last_gap_next;
            interp_reload_reg <= interp_reload_next;
            interp_count_reg  <= interp_count_next;
            interp_on_reg     <= interp_on_next;
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.phase_value <= phase_shifted[12:0];
            m_data_reg.is_running  <= running_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MCLF_ASSERT(a_quarter_range, aclk, aresetn, quarter_reg <= QUARTER_LAST, "quarter out of range")
    `MCLF_ASSERT(a_interp_bounded, aclk, aresetn, interp_count_reg <= interp_reload_reg, "interpolation count above reload")
    `MCLF_ASSERT(a_beat_yields_result, aclk, aresetn, s_accept |=> m_valid_reg, "accepted beat left no result")
    `MCLF_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule

>>> rtl/mclf_gap_timer.sv
// ---------------------------------------------------------------------------
// mclf_gap_timer
// coarse timer measuring the gap between sync pulses, prescaled time ticks
// ---------------------------------------------------------------------------
`include "midi_clock_lfo_phase_follower_unit_defines.svh"

module mclf_gap_timer
    import mclf_pkg::*;
#(
    parameter int COARSE_RATIO = 8,
    parameter int GAP_WIDTH    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mclf_gap_cmd_t        cmd,
    output logic [GAP_WIDTH-1:0] gap_count
);

    localparam int PRE_W = (COARSE_RATIO > 1) ? $clog2(COARSE_RATIO) : 1;
    localparam logic [PRE_W-1:0]     PRE_LAST = PRE_W'(COARSE_RATIO - 1);
    localparam logic [GAP_WIDTH-1:0] GAP_FULL = {GAP_WIDTH{1'b1}};

    logic [PRE_W-1:0]     prescale_reg, prescale_next;
    logic [GAP_WIDTH-1:0] gap_count_reg, gap_count_next;
    logic                 gap_on_reg, gap_on_next;

    always_comb begin
        prescale_next  = prescale_reg;
        gap_count_next = gap_count_reg;
        gap_on_next    = gap_on_reg;
        if (cmd.sync) begin
            prescale_next  = '0;
            gap_count_next = '0;
            gap_on_next    = 1'b1;
        end else if (cmd.stop) begin
            prescale_next  = '0;
            gap_count_next = '0;
            gap_on_next    = 1'b0;
        end else if (cmd.tick && gap_on_reg) begin
            if (prescale_reg == PRE_LAST) begin
                prescale_next = '0;
                // overrun wraps to zero and parks the timer
                if (gap_count_reg == GAP_FULL) begin
                    gap_count_next = '0;
                    gap_on_next    = 1'b0;
                end else begin
                    gap_count_next = gap_count_reg + 1'b1;
                end
            end else begin
                prescale_next = prescale_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg  <= '0;
            gap_count_reg <= '0;
            gap_on_reg    <= 1'b1;
        end else begin
            prescale_reg  <= prescale_next;
            gap_count_reg <= gap_count_next;
            gap_on_reg    <= gap_on_next;
        end
    end

    assign gap_count = gap_count_reg;

    `MCLF_ASSERT(a_parked_is_zero, aclk, aresetn, !gap_on_reg |-> (gap_count_reg == '0), "gap timer parked with nonzero count")
    `MCLF_ASSERT(a_sync_restarts, aclk, aresetn, cmd.sync |=> (gap_on_reg && gap_count_reg == '0 && prescale_reg == '0), "sync did not restart gap timer")

endmodule

>>> bench/midi_clock_lfo_phase_follower_unit_test.sv
// ---------------------------------------------------------------------------
// midi_clock_lfo_phase_follower_unit_test
// self-checking bench for the sync clock phase follower: a scoreboard keeps
// its own copy of the follower state, predicts the phase and running flag
// for every accepted input beat and compares each result beat in order,
// while random idling, a long receiver hold-off and a long pulse run that
// wraps the measure counter exercise the handshake and state
// ---------------------------------------------------------------------------
module midi_clock_lfo_phase_follower_unit_test
    import mclf_pkg::*;
();

    class phase_scoreboard #(int COARSE_RATIO = 8, int GAP_WIDTH = 16, int REPORT_LIMIT = 10);

        typedef logic [GAP_WIDTH-1:0] gap_t;

        logic        running;
        logic [4:0]  quarter_tick;
        logic [3:0]  measure_tick;
        logic [31:0] phase_acc;
        gap_t        measured_gap;
        gap_t        last_gap;
        gap_t        gap_count;
        gap_t        interp_reload;
        gap_t        interp_count;
        logic        gap_count_on;
        logic        interp_on;
        int unsigned prescale;

        mclf_out_t   phase_results_due[$];

        int unsigned mismatches;
        int unsigned compared;
        int unsigned syncs;
        int unsigned gaps_taken;
        int unsigned gaps_refused;
        int unsigned measure_wraps;
        int unsigned interp_steps;

        function new();
            running       = 1'b0;
            quarter_tick  = '0;
            measure_tick  = '0;
            phase_acc     = '0;
            measured_gap  = '0;
            last_gap      = '0;
            gap_count     = '0;
            gap_count_on  = 1'b1;
            prescale      = 0;
            interp_reload = gap_t'(100);
            interp_count  = '0;
            interp_on     = 1'b0;
            mismatches    = 0;
            compared      = 0;
            syncs         = 0;
            gaps_taken    = 0;
            gaps_refused  = 0;
            measure_wraps = 0;
            interp_steps  = 0;
        endfunction

        function void follow_tick();
            if (gap_count_on) begin
                prescale++;
                if (prescale >= COARSE_RATIO) begin
                    prescale = 0;
                    // overrun: timer wraps to zero and stops until the next pulse
                    if (gap_count == '1) begin
                        gap_count    = '0;
                        gap_count_on = 1'b0;
                    end else begin
                        gap_count = gap_count + 1'b1;
                    end
                end
            end
            // a zero reload freezes the interpolation
            if (interp_on && interp_reload != '0) begin
                if (interp_count >= interp_reload) begin
                    interp_count = '0;
                    phase_acc    = phase_acc + INTERP_STEP;
                    interp_steps++;
                end else begin
                    interp_count = interp_count + 1'b1;
                end
            end
        endfunction

        function void follow_sync();
            gap_t gap;
            gap          = gap_count;
            gap_count    = '0;
            prescale     = 0;
            gap_count_on = 1'b1;
            syncs++;
            if (running && gap != '0 && gap != '1) begin
                interp_reload = measured_gap;
                measured_gap  = gap;
                last_gap      = gap;
                interp_on     = 1'b1;
                gaps_taken++;
            end else if (running) begin
                gaps_refused++;
            end
            if (quarter_tick == QUARTER_LAST) begin
                quarter_tick = '0;
                if (measure_tick == 4'hf)
                    measure_wraps++;
                measure_tick = measure_tick + 1'b1;
            end else begin
                quarter_tick = quarter_tick + 1'b1;
            end
            phase_acc    = 32'(quarter_tick) * 32'(SUB_PER_PULSE) + (32'(measure_tick) << 17);
            interp_count = '0;
        endfunction

        function mclf_out_t follow_beat(mclf_in_t b);
            mclf_out_t r;
            case (b.kind)
                KIND_TICK: follow_tick();
                KIND_SYNC: follow_sync();
                KIND_START: begin
                    running       = 1'b1;
                    quarter_tick  = '0;
                    measure_tick  = '0;
                    phase_acc     = '0;
                    measured_gap  = last_gap;
                    interp_reload = last_gap;
                    interp_count  = '0;
                end
                KIND_STOP: begin
                    running      = 1'b0;
                    interp_on    = 1'b0;
                    gap_count_on = 1'b0;
                    gap_count    = '0;
                    prescale     = 0;
                end
                KIND_CONTINUE: running = 1'b1;
                default: ;
            endcase
            r.phase_value = 13'(phase_acc >> b.rate_select);
            r.is_running  = running;
            return r;
        endfunction

        function void note_beat(mclf_in_t b);
            phase_results_due.push_back(follow_beat(b));
        endfunction

        function void check_beat(mclf_out_t got);
            mclf_out_t want;
            compared++;
            if (phase_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with none due: phase_value %0d is_running %0b",
                             compared, got.phase_value, got.is_running);
                return;
            end
            want = phase_results_due.pop_front();
            if (got.phase_value !== want.phase_value || got.is_running !== want.is_running) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d: phase_value exp %0d got %0d, is_running exp %0b got %0b",
                             compared, want.phase_value, got.phase_value,
                             want.is_running, got.is_running);
            end
        endfunction

        function int results_due();
            return phase_results_due.size();
        endfunction

    endclass

    localparam int COARSE_RATIO     = 8;
    localparam int GAP_WIDTH        = 16;
    localparam int IDLE_PCT         = 17;
    localparam int RANDOM_BEATS     = 1100;
    localparam int HOLD_OFF_CYCLES  = 250;
    localparam int MEASURE_BURST    = 400;
    localparam int DRAIN_TAIL       = 4;

    localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
    localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mclf_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    mclf_out_t m_data;

    phase_scoreboard #(.COARSE_RATIO(COARSE_RATIO), .GAP_WIDTH(GAP_WIDTH)) sb;

    int unsigned beats_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          ready_hold_cycles;

    midi_clock_lfo_phase_follower_unit #(
        .COARSE_RATIO (COARSE_RATIO),
        .GAP_WIDTH    (GAP_WIDTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [3:0] rand_rate();
        return 4'($urandom_range(15));
    endfunction

    task automatic send_beat(input logic [2:0] kind, input logic [3:0] rate);
        mclf_in_t b;
        b.kind        = kind;
        b.rate_select = rate;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(b);
        beats_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_beat(KIND_TICK, rand_rate());
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.results_due() != 0) @(posedge aclk);
    endtask

    // rate select follows the beat count so it sweeps 0..15 here
    task automatic run_directed();
        send_beat(KIND_TICK, 4'(beats_sent));
        for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++)
            send_beat(3'(k), 4'(beats_sent));
        send_beat(KIND_CONTINUE, 4'(beats_sent));
        send_beat(KIND_SYNC, 4'(beats_sent));             // zero gap, refused
        repeat (COARSE_RATIO) send_beat(KIND_TICK, 4'(beats_sent));
        send_beat(KIND_SYNC, 4'(beats_sent));             // gap of one, reload still zero
        repeat (2) send_beat(KIND_TICK, 4'(beats_sent));
        send_beat(KIND_START, 4'(beats_sent));
        repeat (3) send_beat(KIND_TICK, 4'(beats_sent));
        send_beat(KIND_STOP, 4'(beats_sent));
        send_beat(KIND_TICK, 4'(beats_sent));
        send_beat(KIND_SYNC, 4'(beats_sent));             // pulse while stopped
    endtask

    task automatic run_random(input int n_beats);
        int unsigned first;
        int unsigned idx;
        int          pick;
        int          pulses;
        bit          hold_done;
        bit          drain_done;
        first      = beats_sent;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (beats_sent - first < n_beats) begin
            idx = beats_sent - first;
            if (!hold_done && idx >= 300) begin
                hold_done         = 1'b1;
                ready_hold_cycles = HOLD_OFF_CYCLES;
            end
            if (!drain_done && idx >= 600) begin
                drain_done = 1'b1;
                wait_drained();
            end
            send_idle_pct = (idx >= 650 && idx < 900) ? 0 : IDLE_PCT;
            recv_idle_pct = send_idle_pct;
            pick = $urandom_range(99);
            if (pick < 50) begin
                // pulse train, mostly with gaps the follower accepts
                pulses = $urandom_range(1, 4);
                repeat (pulses) begin
                    if ($urandom_range(9) == 0)
                        send_ticks($urandom_range(COARSE_RATIO - 1));
                    else
                        send_ticks($urandom_range(COARSE_RATIO, 5 * COARSE_RATIO));
                    send_beat(KIND_SYNC, rand_rate());
                end
            end else if (pick < 58) begin
                send_beat(KIND_START, rand_rate());
            end else if (pick < 63) begin
                send_beat(KIND_STOP, rand_rate());
            end else if (pick < 70) begin
                send_beat(KIND_CONTINUE, rand_rate());
            end else if (pick < 78) begin
                repeat ($urandom_range(2, 30)) send_beat(KIND_SYNC, rand_rate());
            end else if (pick < 88) begin
                send_ticks($urandom_range(1, 40));
            end else begin
                repeat ($urandom_range(1, 4)) send_beat(3'($urandom_range(7)), rand_rate());
            end
        end
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // a run of pulses long enough to wrap the measure counter
    task automatic run_measure_wrap();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_beat(KIND_START, rand_rate());
        repeat (MEASURE_BURST) send_beat(KIND_SYNC, rand_rate());
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    // result side: random stalls plus the requested hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (ready_hold_cycles > 0) begin
                m_ready <= 1'b0;
                ready_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_beat(m_data);
        end
    end

    initial begin
        sb                = new();
        beats_sent        = 0;
        send_idle_pct     = IDLE_PCT;
        recv_idle_pct     = IDLE_PCT;
        ready_hold_cycles = 0;
        s_valid           = 1'b0;
        s_data            = '0;
        aresetn           = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(RANDOM_BEATS);
        run_measure_wrap();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("run covered %0d input beats, %0d results compared, %0d sync pulses",
                 beats_sent, sb.compared, sb.syncs);
        $display("gaps taken %0d, refused %0d, measure wraps %0d, %0d interp steps",
                 sb.gaps_taken, sb.gaps_refused, sb.measure_wraps, sb.interp_steps);
        if (sb.mismatches == 0 && sb.results_due() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mclf_pkg.sv
rtl/mclf_gap_timer.sv
rtl/midi_clock_lfo_phase_follower_unit.sv
bench/midi_clock_lfo_phase_follower_unit_test.sv
